### hw/rtl/hbme_pkg.sv
package hbme_pkg;

	localparam int BYTE_W     = 8;
	localparam int VALUE_W    = 18;
	localparam int NUM_COLS   = 4;
	localparam int DIM_W      = 3;
	localparam int REM_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 3'd4;

	// Key matrix: row, then column, column 0 in the low byte of a row.
	typedef logic [NUM_COLS-1:0][NUM_COLS-1:0][BYTE_W-1:0] key_mat_t;
	typedef logic [NUM_COLS-1:0][BYTE_W-1:0] vec_t;
	typedef logic [NUM_COLS-1:0][VALUE_W-1:0] sums_t;

endpackage

### hw/rtl/hbme_product.sv
module hbme_product (
	input  hbme_pkg::vec_t     vec,
	input  hbme_pkg::key_mat_t key,
	output hbme_pkg::sums_t    sums
);

	logic [2*hbme_pkg::BYTE_W-1:0] prod;

	// Row vector times key matrix; entries of the vector beyond the active
	// size are already zero, so every column sums over all four rows.
	always_comb begin
		sums = '0;
		prod = '0;
		for (int c = 0; c < hbme_pkg::NUM_COLS; c++) begin
			for (int j = 0; j < hbme_pkg::NUM_COLS; j++) begin
				prod = vec[j] * key[j][c];
				sums[c] = sums[c] + {2'b00, prod};
			end
		end
	end

endmodule

### hw/rtl/hill_block_matrix_encrypt_core.sv
// Hill-style block encryptor without modulus.
// Input channel (in_valid, in_stall, message_byte, final_byte): one message
// byte per beat. Bytes gather into a block of n, n taken from matrix_dim.
// When a block fills, or a byte with final_byte set arrives, the block (zero
// padded) is multiplied by the key matrix and n results follow on the output
// channel (out_valid, out_stall, cipher_value, block_end), column 0 first,
// block_end high on the last one.
// The first result of a block is presented the cycle after the completing
// byte is taken. With out_stall low, full blocks of n bytes, each yielding
// n results, stream without pause at one byte per cycle. in_stall rises
// only for a byte that would complete a block while more than one result of
// the previous block is still waiting (or one is waiting and out_stall is
// high). A stalled output holds its beat unchanged; no results are lost.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// it must be written only while the block is idle, which the block does not
// enforce. Index 0 is matrix_dim, 1..4 key rows 0..3; others are ignored.
// Reset clears the block buffer, the pending results and the keys, and sets
// matrix_dim to 1.
module hill_block_matrix_encrypt_core #(
	parameter int MAX_DIM = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hbme_pkg::BYTE_W-1:0]         message_byte,
	input  logic                                final_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hbme_pkg::VALUE_W-1:0]        cipher_value,
	output logic                                block_end,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hbme_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hbme_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CAP   = (MAX_DIM < hbme_pkg::NUM_COLS) ? MAX_DIM : hbme_pkg::NUM_COLS;
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam logic [hbme_pkg::DIM_W-1:0] CAP_DIM = hbme_pkg::DIM_W'(CAP);

	logic [hbme_pkg::DIM_W-1:0]  dim_q;
	hbme_pkg::key_mat_t          key_q;
	logic [MAX_DIM-1:0][hbme_pkg::BYTE_W-1:0] buf_q;
	logic [IDX_W-1:0]            fill_q;
	hbme_pkg::sums_t             vals_q;
	logic [hbme_pkg::REM_W-1:0]  rem_q;

	logic [hbme_pkg::DIM_W-1:0]  n_act;
	hbme_pkg::vec_t              buf_pad;
	hbme_pkg::vec_t              vec;
	hbme_pkg::sums_t             sums;
	logic [IDX_W:0]              fill_next;
	logic                        complete;
	logic                        bank_free;
	logic                        in_take;
	logic                        out_take;
	logic                        load;

	always_comb begin
		priority if (dim_q == '0) begin
			n_act = hbme_pkg::DIM_W'(1);
		end else if (dim_q > CAP_DIM) begin
			n_act = CAP_DIM;
		end else begin
			n_act = dim_q;
		end
	end

	for (genvar j = 0; j < hbme_pkg::NUM_COLS; j++) begin : g_pad
		if (j < MAX_DIM) begin : g_used
			assign buf_pad[j] = buf_q[j];
		end else begin : g_unused
			assign buf_pad[j] = '0;
		end
	end

	// The incoming byte takes its place in the block before the product.
	always_comb begin
		for (int j = 0; j < hbme_pkg::NUM_COLS; j++) begin
			if (j >= int'(n_act)) begin
				vec[j] = '0;
			end else if (j == int'(fill_q)) begin
				vec[j] = message_byte;
			end else begin
				vec[j] = buf_pad[j];
			end
		end
	end

	hbme_product u_product (
		.vec  (vec),
		.key  (key_q),
		.sums (sums)
	);

	assign fill_next = {1'b0, fill_q} + (IDX_W+1)'(1);
	assign complete  = final_byte || (int'(fill_next) >= int'(n_act));
	assign out_valid = (rem_q != '0);
	assign out_take  = out_valid && !out_stall;
	assign bank_free = (rem_q == '0) || ((rem_q == hbme_pkg::REM_W'(1)) && !out_stall);
	assign in_stall  = complete && !bank_free;
	assign in_take   = in_valid && !in_stall;
	assign load      = in_take && complete;

	assign cipher_value = vals_q[0];
	assign block_end    = (rem_q == hbme_pkg::REM_W'(1));
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= hbme_pkg::DIM_W'(1);
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hbme_pkg::CFG_DIM:  dim_q    <= cfg_data[hbme_pkg::DIM_W-1:0];
				hbme_pkg::CFG_KEY0: key_q[0] <= cfg_data;
				hbme_pkg::CFG_KEY1: key_q[1] <= cfg_data;
				hbme_pkg::CFG_KEY2: key_q[2] <= cfg_data;
				hbme_pkg::CFG_KEY3: key_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			fill_q <= '0;
		end else if (load) begin
			buf_q  <= '0;
			fill_q <= '0;
		end else if (in_take) begin
			buf_q[fill_q] <= message_byte;
			fill_q        <= fill_next[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= n_act;
		end else if (out_take) begin
			rem_q <= rem_q - hbme_pkg::REM_W'(1);
		end
	end

	// Result bank: head is presented, the rest shift down as beats leave.
	always_ff @(posedge clk) begin
		if (load) begin
			vals_q <= sums;
		end else if (out_take) begin
			for (int i = 0; i < hbme_pkg::NUM_COLS - 1; i++) begin
				vals_q[i] <= vals_q[i+1];
			end
		end
	end

endmodule

### hw/rtl/hbme_checker.sv
module hbme_sva (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            final_byte,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [hbme_pkg::VALUE_W-1:0]    cipher_value,
	input logic                            block_end
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_value) && $stable(block_end))
		else $error("result beat changed while stalled");

	// A final byte always flushes its block, so results follow at once.
	a_final_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_byte |=> out_valid)
		else $error("final byte taken without a result the next cycle");

	// Input is held back only by results still waiting to leave.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

	// Four byte-by-byte products cannot exceed 4 * 255 * 255.
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cipher_value <= 18'd260100)
		else $error("result above the largest possible dot product");

endmodule

bind hill_block_matrix_encrypt_core hbme_sva u_hbme_sva (.*);

### dv/hbme_checker.sv
module hbme_checker
	import hbme_pkg::*;
#(
	parameter int MAX_DIM = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [BYTE_W-1:0]     message_byte,
	input  logic                  final_byte,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [VALUE_W-1:0]    cipher_value,
	input  logic                  block_end,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// One block never yields more results than there are key columns.
	localparam int DIM_CAP = (MAX_DIM < NUM_COLS) ? MAX_DIM : NUM_COLS;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} cipher_beat_t;

	logic [DIM_W-1:0]      dim_setting = 3'd1;
	logic [CFG_DATA_W-1:0] key_rows [NUM_COLS];
	logic [BYTE_W-1:0]     block_bytes [MAX_DIM];
	int                    bytes_held = 0;
	cipher_beat_t          cipher_q [$];

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk or negedge arst_n) begin
		int           side;
		logic [31:0]  acc;
		cipher_beat_t want;
		if (!arst_n) begin
			dim_setting = 3'd1;
			for (int r = 0; r < NUM_COLS; r++)
				key_rows[r] = '0;
			for (int j = 0; j < MAX_DIM; j++)
				block_bytes[j] = '0;
			bytes_held = 0;
			cipher_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DIM:  dim_setting = cfg_data[DIM_W-1:0];
					CFG_KEY0: key_rows[0] = cfg_data;
					CFG_KEY1: key_rows[1] = cfg_data;
					CFG_KEY2: key_rows[2] = cfg_data;
					CFG_KEY3: key_rows[3] = cfg_data;
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					$display("%0t: cipher beat %0d block_end %0b arrived with none expected",
						$time, cipher_value, block_end);
					fail_count++;
				end else begin
					want = cipher_q.pop_front();
					if (cipher_value !== want.value) begin
						$display("%0t: cipher_value expected %0d actual %0d",
							$time, want.value, cipher_value);
						fail_count++;
					end
					if (block_end !== want.last) begin
						$display("%0t: block_end expected %0b actual %0b",
							$time, want.last, block_end);
						fail_count++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				// A size of zero acts as one; anything above the cap acts as the cap.
				if (dim_setting == 0)
					side = 1;
				else if (dim_setting > DIM_CAP)
					side = DIM_CAP;
				else
					side = int'(dim_setting);

				if (bytes_held < MAX_DIM)
					block_bytes[bytes_held] = message_byte;
				bytes_held++;

				// A shrunken size may leave more bytes held than the block uses;
				// only the first positions take part in the product.
				if (bytes_held >= side || final_byte) begin
					for (int c = 0; c < side; c++) begin
						acc = '0;
						for (int j = 0; j < side; j++)
							acc += block_bytes[j] * key_rows[j][8*c +: 8];
						want.value = acc[VALUE_W-1:0];
						want.last  = (c == side - 1);
						cipher_q.push_back(want);
					end
					for (int j = 0; j < MAX_DIM; j++)
						block_bytes[j] = '0;
					bytes_held = 0;
				end
			end

			pending = cipher_q.size();
		end
	end

endmodule

### dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hbme_pkg::*;

	localparam int MAX_DIM       = 4;
	localparam int LIMIT_CYCLES  = 100000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 60;

	localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED_HI = 3'd7;
	localparam logic [CFG_DATA_W-1:0] KEY_ALL       = 32'hFFFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid;
	logic                  in_stall;
	logic [BYTE_W-1:0]     message_byte;
	logic                  final_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [VALUE_W-1:0]    cipher_value;
	logic                  block_end;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   send_idle_pct = 15;
	int   recv_idle_pct = 78;
	logic hold_req = 1'b0;

	hill_block_matrix_encrypt_core #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.message_byte(message_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cipher_value(cipher_value),
		.block_end(block_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hbme_checker #(
		.MAX_DIM(MAX_DIM)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.message_byte(message_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cipher_value(cipher_value),
		.block_end(block_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request so the
	// block fills up and has to stall its input.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req <= 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Leaves in_valid high after the beat so that back-to-back bytes never
	// drop and raise it in the same step.
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		message_byte <= value;
		final_byte   <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_config(input logic [DIM_W-1:0] dim,
			input logic [CFG_DATA_W-1:0] k0, k1, k2, k3);
		set_reg(CFG_DIM, CFG_DATA_W'(dim));
		set_reg(CFG_KEY0, k0);
		set_reg(CFG_KEY1, k1);
		set_reg(CFG_KEY2, k2);
		set_reg(CFG_KEY3, k3);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering bytes and wait until every result is out. A byte that
	// completes no block leaves nothing to wait on, so a settling wait follows.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_key();
		case ($urandom_range(7))
			0: return '0;
			1: return KEY_ALL;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		if ($urandom_range(4) == 0)
			return DIM_W'($urandom_range(7));
		return DIM_W'($urandom_range(4, 1));
	endfunction

	// Mostly whole messages closed by a final byte, with stray bytes between.
	task automatic run_traffic(input int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) < 8) begin
				len = $urandom_range(9, 1);
				for (int i = 0; i < len; i++)
					send_byte(BYTE_W'($urandom_range(255)), i == len - 1);
				sent += len;
			end else begin
				send_byte(BYTE_W'($urandom_range(255)), $urandom_range(2) == 0);
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		for (int k = 0; k < 2; k++) begin
			load_config(pick_dim(), pick_key(), pick_key(), pick_key(), pick_key());
			run_traffic(10);
			quiesce();
		end
	endtask

	initial begin
		in_valid     = 1'b0;
		message_byte = '0;
		final_byte   = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Out of reset the size is one and the key is zero.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b1);
		quiesce();

		load_config(3'd4, KEY_ALL, KEY_ALL, KEY_ALL, KEY_ALL);
		@(negedge clk);
		// Writes past the register list must not disturb size or key.
		set_reg(CFG_UNUSED_LO, 32'h0000_0001);
		set_reg(CFG_UNUSED_HI, 32'h0000_0002);
		cfg_valid <= 1'b0;

		// Largest values, then short blocks padded with zeros.
		for (int i = 0; i < 4; i++)
			send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h01, 1'b1);

		// Shrink the size with three bytes already held.
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h33, 1'b0);
		quiesce();
		load_config(3'd2, 32'h0403_0201, 32'h0807_0605, 32'h0C0B_0A09, 32'h100F_0E0D);
		send_byte(8'h44, 1'b0);
		quiesce();

		// Size zero behaves as one.
		load_config(3'd0, 32'h0000_00FF, KEY_ALL, KEY_ALL, KEY_ALL);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h7F, 1'b0);
		quiesce();

		// Sizes above four behave as four.
		load_config(3'd7, KEY_ALL, 32'h0000_0000, KEY_ALL, 32'h8040_2010);
		for (int i = 0; i < 4; i++)
			send_byte(8'h01 << (2 * i), 1'b0);
		send_byte(8'hC3, 1'b1);
		quiesce();
		load_config(3'd5, pick_key(), pick_key(), pick_key(), pick_key());
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		quiesce();

		run_phase(15, 78);
		run_phase(78, 15);
		run_phase(0, 0);

		load_config(3'd4, pick_key(), pick_key(), pick_key(), pick_key());
		hold_req <= 1'b1;
		for (int i = 0; i < 16; i++)
			send_byte(BYTE_W'($urandom_range(255)), 1'b0);
		quiesce();

		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
